/* rtl/window_color_frequency_count_unit_defines.svh */
// assertion macros for the window colour frequency count unit
`ifndef WINDOW_COLOR_FREQUENCY_COUNT_UNIT_DEFINES_SVH
`define WINDOW_COLOR_FREQUENCY_COUNT_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge out of reset
`define WCF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen out of reset
`define WCF_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define WCF_ASSERT(label, prop, msg)
`define WCF_ASSERT_NEVER(label, cond, msg)
`endif

`endif

/* rtl/wcf_pkg.sv */
`timescale 1ns / 1ps

package wcf_pkg;

    // default sizes
    localparam int DEF_TOUR_DEPTH   = 2048;
    localparam int DEF_VERTEX_COUNT = 1024;
    localparam int DEF_COLOR_COUNT  = 1024;

    // item modes
    localparam logic [1:0] MODE_TOUR  = 2'd0;
    localparam logic [1:0] MODE_COLOR = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // lookup memory controls
    typedef struct packed {
        logic tour_wr;
        logic tour_rd;
        logic color_wr;
        logic color_rd;
    } lkp_ctl_t;

    // count table controls
    typedef struct packed {
        logic occ_wr;
        logic occ_rd;
        logic cnt_wr;
        logic cnt_rd;
    } tbl_ctl_t;

endpackage

/* rtl/wcf_lookup.sv */
`timescale 1ns / 1ps

module wcf_lookup #(
    parameter int TOUR_DEPTH   = wcf_pkg::DEF_TOUR_DEPTH,
    parameter int VERTEX_COUNT = wcf_pkg::DEF_VERTEX_COUNT,
    parameter int COLOR_COUNT  = wcf_pkg::DEF_COLOR_COUNT,
    parameter int POS_W        = $clog2(TOUR_DEPTH + 2),
    parameter int VTX_W        = $clog2(VERTEX_COUNT + 1),
    parameter int COL_W        = $clog2(COLOR_COUNT + 1)
) (
    input  logic              clk,
    input  wcf_pkg::lkp_ctl_t ctl,
    input  logic [POS_W-1:0]  tour_wr_addr,
    input  logic [VTX_W-1:0]  tour_wr_data,
    input  logic [POS_W-1:0]  tour_rd_addr,
    input  logic [VTX_W-1:0]  color_wr_addr,
    input  logic [COL_W-1:0]  color_wr_data,
    input  logic [VTX_W-1:0]  color_rd_addr,
    output logic [VTX_W-1:0]  tour_rdata,
    output logic [COL_W-1:0]  color_rdata
);
    import wcf_pkg::*;

    logic [VTX_W-1:0] tour_mem [0:TOUR_DEPTH];
    logic [COL_W-1:0] color_mem [0:VERTEX_COUNT];

    // tour table, vertex per position
    always_ff @(posedge clk)
    begin
        if (ctl.tour_wr)
        begin
            tour_mem[tour_wr_addr] <= tour_wr_data;
        end
        if (ctl.tour_rd)
        begin
            tour_rdata <= tour_mem[tour_rd_addr];
        end
    end

    // colour per vertex
    always_ff @(posedge clk)
    begin
        if (ctl.color_wr)
        begin
            color_mem[color_wr_addr] <= color_wr_data;
        end
        if (ctl.color_rd)
        begin
            color_rdata <= color_mem[color_rd_addr];
        end
    end

endmodule

/* rtl/wcf_tables.sv */
`timescale 1ns / 1ps

module wcf_tables #(
    parameter int TOUR_DEPTH  = wcf_pkg::DEF_TOUR_DEPTH,
    parameter int COLOR_COUNT = wcf_pkg::DEF_COLOR_COUNT,
    parameter int POS_W       = $clog2(TOUR_DEPTH + 2),
    parameter int COL_W       = $clog2(COLOR_COUNT + 1),
    parameter int CNT_W       = $clog2(COLOR_COUNT + 2)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wcf_pkg::tbl_ctl_t ctl,
    input  logic [COL_W-1:0]  occ_addr,
    input  logic [POS_W-1:0]  occ_wr_data,
    input  logic [POS_W-1:0]  cnt_wr_addr,
    input  logic [CNT_W-1:0]  cnt_wr_data,
    input  logic [POS_W-1:0]  cnt_rd_addr,
    output logic [POS_W-1:0]  occ_rdata,
    output logic [CNT_W-1:0]  cnt_rdata,
    output logic              busy
);
    import wcf_pkg::*;

    localparam int CLR_LAST = (COLOR_COUNT > TOUR_DEPTH + 1) ? COLOR_COUNT : TOUR_DEPTH + 1;
    localparam int CLR_W    = $clog2(CLR_LAST + 1);

    logic [POS_W-1:0] occ_mem [0:COLOR_COUNT];
    logic [CNT_W-1:0] cnt_mem [0:TOUR_DEPTH+1];

    logic [CLR_W-1:0] clr_reg, clr_next;
    logic             busy_reg, busy_next;

    logic             occ_we, cnt_we;
    logic [COL_W-1:0] occ_wa;
    logic [POS_W-1:0] occ_wd, cnt_wa;
    logic [CNT_W-1:0] cnt_wd;

    // clearing pass after reset
    always_comb
    begin
        clr_next  = clr_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            clr_next = clr_reg + 1'b1;
            if (clr_reg == CLR_W'(CLR_LAST))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else
        begin
            clr_reg  <= clr_next;
            busy_reg <= busy_next;
        end
    end

    // write port select, clearing or update
    always_comb
    begin
        if (busy_reg)
        begin
            occ_we = (32'(clr_reg) <= COLOR_COUNT);
            occ_wa = COL_W'(clr_reg);
            occ_wd = '0;
            cnt_we = (32'(clr_reg) <= TOUR_DEPTH + 1);
            cnt_wa = POS_W'(clr_reg);
            cnt_wd = '0;
        end
        else
        begin
            occ_we = ctl.occ_wr;
            occ_wa = occ_addr;
            occ_wd = occ_wr_data;
            cnt_we = ctl.cnt_wr;
            cnt_wa = cnt_wr_addr;
            cnt_wd = cnt_wr_data;
        end
    end

    // occurrences per colour
    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[occ_wa] <= occ_wd;
        end
        if (ctl.occ_rd)
        begin
            occ_rdata <= occ_mem[occ_addr];
        end
    end

    // colours with at least f occurrences
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (ctl.cnt_rd)
        begin
            cnt_rdata <= cnt_mem[cnt_rd_addr];
        end
    end

    assign busy = busy_reg;

endmodule

/* rtl/window_color_frequency_count_unit.sv */
`timescale 1ns / 1ps
// window colour frequency count unit
// input channel (in_valid/in_ready): one item per transfer, mode selects a tour
// entry load, a vertex colour load or a window query; mode 3 is ignored.
// output channel (out_valid/out_ready): one result per query, none for loads.
// a query walks the window ends one position at a time; each position goes
// through a tour read, colour read, occurrence read, count read and count
// write on the registered memory ports; the count read and write are
// skipped when the update is dropped.
// the result sits in an output register; a stalled receiver holds it there,
// the next query may be taken and computed but waits before delivering.
// after reset the occurrence and count tables are cleared one entry a cycle
// while in_ready stays low.
`include "window_color_frequency_count_unit_defines.svh"

module window_color_frequency_count_unit #(
    parameter int TOUR_DEPTH   = wcf_pkg::DEF_TOUR_DEPTH,
    parameter int VERTEX_COUNT = wcf_pkg::DEF_VERTEX_COUNT,
    parameter int COLOR_COUNT  = wcf_pkg::DEF_COLOR_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [11:0] address,
    input  logic [10:0] load_value,
    input  logic [11:0] range_start,
    input  logic [11:0] range_end,
    input  logic [10:0] min_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] matching_colors
);
    import wcf_pkg::*;

    localparam int POS_W = $clog2(TOUR_DEPTH + 2);
    localparam int VTX_W = $clog2(VERTEX_COUNT + 1);
    localparam int COL_W = $clog2(COLOR_COUNT + 1);
    localparam int CNT_W = $clog2(COLOR_COUNT + 2);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MOVE  = 7'b0000010,
        S_TOUR  = 7'b0000100,
        S_COLOR = 7'b0001000,
        S_OCC   = 7'b0010000,
        S_CNT   = 7'b0100000,
        S_ANS   = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] left_reg, left_next, right_reg, right_next;
    logic [POS_W-1:0] start_reg, start_next, stop_reg, stop_next;
    logic [POS_W-1:0] thr_reg, thr_next, idx_reg, idx_next;
    logic             thr_big_reg, thr_big_next, add_reg, add_next;
    logic [COL_W-1:0] color_reg, color_next;
    logic             out_valid_reg, out_valid_next;
    logic [10:0]      out_data_reg, out_data_next;

    lkp_ctl_t         lkp_ctl;
    tbl_ctl_t         tbl_ctl;
    logic [POS_W-1:0] tour_rd_addr, occ_wr_data, cnt_wr_addr, cnt_rd_addr;
    logic [VTX_W-1:0] tour_rdata;
    logic [COL_W-1:0] color_rdata, occ_addr;
    logic [POS_W-1:0] occ_rdata;
    logic [CNT_W-1:0] cnt_wr_data, cnt_rdata;
    logic             tbl_busy;

    logic             in_xfer, out_xfer, out_free;
    logic [POS_W-1:0] s_sat, e_sat;
    logic [11:0]      thr_in;

    assign in_ready = (state_reg == S_IDLE) && !tbl_busy;
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;
    assign out_free = !out_valid_reg || out_ready;

    // window bounds saturate to the tour depth
    assign s_sat  = (32'(range_start) > TOUR_DEPTH) ? POS_W'(TOUR_DEPTH) : POS_W'(range_start);
    assign e_sat  = (32'(range_end) > TOUR_DEPTH) ? POS_W'(TOUR_DEPTH) : POS_W'(range_end);
    assign thr_in = {min_count, 1'b0};

    wcf_lookup #(
        .TOUR_DEPTH   (TOUR_DEPTH),
        .VERTEX_COUNT (VERTEX_COUNT),
        .COLOR_COUNT  (COLOR_COUNT),
        .POS_W        (POS_W),
        .VTX_W        (VTX_W),
        .COL_W        (COL_W)
    ) u_lookup (
        .clk           (clk),
        .ctl           (lkp_ctl),
        .tour_wr_addr  (POS_W'(address)),
        .tour_wr_data  (VTX_W'(load_value)),
        .tour_rd_addr  (tour_rd_addr),
        .color_wr_addr (VTX_W'(address)),
        .color_wr_data (COL_W'(load_value)),
        .color_rd_addr (tour_rdata),
        .tour_rdata    (tour_rdata),
        .color_rdata   (color_rdata)
    );

    wcf_tables #(
        .TOUR_DEPTH  (TOUR_DEPTH),
        .COLOR_COUNT (COLOR_COUNT),
        .POS_W       (POS_W),
        .COL_W       (COL_W),
        .CNT_W       (CNT_W)
    ) u_tables (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (tbl_ctl),
        .occ_addr    (occ_addr),
        .occ_wr_data (occ_wr_data),
        .cnt_wr_addr (cnt_wr_addr),
        .cnt_wr_data (cnt_wr_data),
        .cnt_rd_addr (cnt_rd_addr),
        .occ_rdata   (occ_rdata),
        .cnt_rdata   (cnt_rdata),
        .busy        (tbl_busy)
    );

    // query sequencer
    always_comb
    begin
        state_next     = state_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        start_next     = start_reg;
        stop_next      = stop_reg;
        thr_next       = thr_reg;
        thr_big_next   = thr_big_reg;
        idx_next       = idx_reg;
        add_next       = add_reg;
        color_next     = color_reg;
        out_valid_next = out_valid_reg && !out_xfer;
        out_data_next  = out_data_reg;
        lkp_ctl        = '0;
        tbl_ctl        = '0;
        tour_rd_addr   = left_reg;
        occ_addr       = color_reg;
        occ_wr_data    = '0;
        cnt_wr_addr    = idx_reg;
        cnt_wr_data    = '0;
        cnt_rd_addr    = thr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (mode)
                        MODE_TOUR:
                        begin
                            lkp_ctl.tour_wr = (32'(address) <= TOUR_DEPTH)
                                && (32'(load_value) <= VERTEX_COUNT);
                        end
                        MODE_COLOR:
                        begin
                            lkp_ctl.color_wr = (32'(address) <= VERTEX_COUNT)
                                && (32'(load_value) <= COLOR_COUNT);
                        end
                        MODE_QUERY:
                        begin
                            start_next   = s_sat;
                            stop_next    = (e_sat < s_sat) ? s_sat : e_sat + 1'b1;
                            thr_big_next = (32'(thr_in) > TOUR_DEPTH);
                            thr_next     = POS_W'(thr_in);
                            state_next   = S_MOVE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MOVE:
            begin
                // grow the window first, then shrink it
                if (left_reg > start_reg)
                begin
                    left_next       = left_reg - 1'b1;
                    tour_rd_addr    = left_reg - 1'b1;
                    add_next        = 1'b1;
                    lkp_ctl.tour_rd = 1'b1;
                    state_next      = S_TOUR;
                end
                else if (right_reg < stop_reg)
                begin
                    right_next      = right_reg + 1'b1;
                    tour_rd_addr    = right_reg;
                    add_next        = 1'b1;
                    lkp_ctl.tour_rd = 1'b1;
                    state_next      = S_TOUR;
                end
                else if (left_reg < start_reg)
                begin
                    left_next       = left_reg + 1'b1;
                    tour_rd_addr    = left_reg;
                    add_next        = 1'b0;
                    lkp_ctl.tour_rd = 1'b1;
                    state_next      = S_TOUR;
                end
                else if (right_reg > stop_reg)
                begin
                    right_next      = right_reg - 1'b1;
                    tour_rd_addr    = right_reg - 1'b1;
                    add_next        = 1'b0;
                    lkp_ctl.tour_rd = 1'b1;
                    state_next      = S_TOUR;
                end
                else
                begin
                    // window in place, fetch the answer
                    tbl_ctl.cnt_rd = !thr_big_reg;
                    state_next     = S_ANS;
                end
            end
            S_TOUR:
            begin
                lkp_ctl.color_rd = 1'b1;
                state_next       = S_COLOR;
            end
            S_COLOR:
            begin
                color_next     = color_rdata;
                occ_addr       = color_rdata;
                tbl_ctl.occ_rd = 1'b1;
                state_next     = S_OCC;
            end
            S_OCC:
            begin
                state_next = S_MOVE;
                if (add_reg)
                begin
                    // capped colour is left alone
                    if (32'(occ_rdata) < TOUR_DEPTH + 1)
                    begin
                        occ_wr_data    = occ_rdata + 1'b1;
                        tbl_ctl.occ_wr = 1'b1;
                        idx_next       = occ_rdata + 1'b1;
                        cnt_rd_addr    = occ_rdata + 1'b1;
                        tbl_ctl.cnt_rd = 1'b1;
                        state_next     = S_CNT;
                    end
                end
                else if (occ_rdata != '0)
                begin
                    // removing an absent colour is dropped
                    occ_wr_data    = occ_rdata - 1'b1;
                    tbl_ctl.occ_wr = 1'b1;
                    idx_next       = occ_rdata;
                    cnt_rd_addr    = occ_rdata;
                    tbl_ctl.cnt_rd = 1'b1;
                    state_next     = S_CNT;
                end
            end
            S_CNT:
            begin
                if (add_reg)
                begin
                    cnt_wr_data    = cnt_rdata + 1'b1;
                    tbl_ctl.cnt_wr = 1'b1;
                end
                else
                begin
                    cnt_wr_data    = cnt_rdata - 1'b1;
                    tbl_ctl.cnt_wr = (cnt_rdata != '0);
                end
                state_next = S_MOVE;
            end
            S_ANS:
            begin
                // wait for the output register to free up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = thr_big_reg ? 11'd0 : 11'(cnt_rdata);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            left_reg      <= '0;
            right_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        start_reg    <= start_next;
        stop_reg     <= stop_next;
        thr_reg      <= thr_next;
        thr_big_reg  <= thr_big_next;
        idx_reg      <= idx_next;
        add_reg      <= add_next;
        color_reg    <= color_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid       = out_valid_reg;
    assign matching_colors = out_data_reg;

    // checks
    `WCF_ASSERT_NEVER(a_ready_in_clear, in_ready && tbl_busy, "item taken during clearing")
    `WCF_ASSERT(a_window_order, left_reg <= right_reg, "window ends crossed")
    `WCF_ASSERT(a_window_bound, 32'(right_reg) <= TOUR_DEPTH + 1, "window end past tour")
    `WCF_ASSERT(a_result_held, out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_data_reg), "result lost under stall")

endmodule

/* tb/sv/tb_window_color_frequency_count_unit.sv */
`timescale 1ns / 1ps

module tb_window_color_frequency_count_unit;
    import wcf_pkg::*;

    localparam int TD = DEF_TOUR_DEPTH;
    localparam int VC = DEF_VERTEX_COUNT;
    localparam int CC = DEF_COLOR_COUNT;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [11:0] address;
    logic [10:0] load_value;
    logic [11:0] range_start;
    logic [11:0] range_end;
    logic [10:0] min_count;
    logic        out_valid;
    logic        out_ready;
    logic [10:0] matching_colors;

    window_color_frequency_count_unit DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .address(address), .load_value(load_value),
        .range_start(range_start), .range_end(range_end), .min_count(min_count),
        .out_valid(out_valid), .out_ready(out_ready),
        .matching_colors(matching_colors)
    );

    // predictor state
    int unsigned tour_mem [0:TD];
    int unsigned vcol_mem [0:VC];
    int unsigned occ_tbl [0:CC];
    int unsigned atl_tbl [0:TD+1];
    int unsigned win_lo;
    int unsigned win_hi;
    logic [10:0] expected_counts [$];
    int          errors;
    int          n_queries;
    int          n_loads;
    int          n_sent;

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int unsigned colour_of(int unsigned pos);
        int unsigned v;
        if (pos > TD) return 0;
        v = tour_mem[pos];
        if (v > VC) return 0;
        return (vcol_mem[v] <= CC) ? vcol_mem[v] : 0;
    endfunction

    function automatic void enter_pos(int unsigned pos);
        int unsigned c;
        c = colour_of(pos);
        if (occ_tbl[c] >= TD + 1) return;
        occ_tbl[c]++;
        atl_tbl[occ_tbl[c]]++;
    endfunction

    function automatic void leave_pos(int unsigned pos);
        int unsigned c;
        int unsigned f;
        c = colour_of(pos);
        f = occ_tbl[c];
        if (f == 0) return;
        if (atl_tbl[f] > 0) atl_tbl[f]--;
        occ_tbl[c] = f - 1;
    endfunction

    function automatic void predict_item(logic [1:0] m, logic [11:0] a, logic [10:0] v,
                                         logic [11:0] rs, logic [11:0] re,
                                         logic [10:0] mc);
        int unsigned s;
        int unsigned e;
        int unsigned thr;
        int unsigned stop;
        if (m == MODE_TOUR)
        begin
            if (a <= TD && v <= VC) tour_mem[a] = v;
        end
        else if (m == MODE_COLOR)
        begin
            if (a <= VC && v <= CC) vcol_mem[a] = v;
        end
        else if (m == MODE_QUERY)
        begin
            s = (rs > TD) ? TD : rs;
            e = (re > TD) ? TD : re;
            thr = 2 * mc;
            stop = (e < s) ? s : e + 1;
            while (win_lo > s) begin win_lo--; enter_pos(win_lo); end
            while (win_hi < stop) begin enter_pos(win_hi); win_hi++; end
            while (win_lo < s) begin leave_pos(win_lo); win_lo++; end
            while (win_hi > stop) begin win_hi--; leave_pos(win_hi); end
            expected_counts = {expected_counts,
                               ((thr > TD) ? 11'd0 : atl_tbl[thr][10:0])};
        end
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one item, changing inputs at the falling edge
    task automatic send_item(logic [1:0] m, logic [11:0] a, logic [10:0] v,
                             logic [11:0] rs, logic [11:0] re, logic [10:0] mc);
        int g;
        in_valid    <= 1'b1;
        mode        <= m;
        address     <= a;
        load_value  <= v;
        range_start <= rs;
        range_end   <= re;
        min_count   <= mc;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_item(m, a, v, rs, re, mc);
        if (m == MODE_QUERY) n_queries++;
        else n_loads++;
        n_sent++;
        @(negedge clk);
        // idle gap before the next transfer
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    // receiver stalls
    initial
    begin
        int g;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            g = gap_len();
            if (g == 0) out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
        end
    end

    // check each result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_counts.size() == 0)
            begin
                $error("unexpected result matching_colors=%0d", matching_colors);
                errors++;
            end
            else
            begin
                if (matching_colors !== expected_counts[0])
                begin
                    $error("matching_colors expected %0d actual %0d",
                           expected_counts[0], matching_colors);
                    errors++;
                end
                void'(expected_counts.pop_front());
            end
        end
    end

    // load a full small tree: positions 0..n, vertices and colours written
    task automatic load_tables(int n, int ncol);
        for (int p = 0; p <= n; p++)
            send_item(MODE_TOUR, p, $urandom_range(0, n), 0, 0, 0);
        for (int v = 0; v <= n; v++)
            send_item(MODE_COLOR, v, $urandom_range(0, ncol - 1), 0, 0, 0);
    endtask

    task automatic test_directed();
        // small tour, all positions 0..16 and vertices 0..16 written
        load_tables(16, 3);
        // extreme field values and out-of-range loads (ignored)
        send_item(MODE_TOUR, 12'hFFF, 11'd5, 0, 0, 0);
        send_item(MODE_TOUR, 12'd3, 11'h7FF, 0, 0, 0);
        send_item(MODE_COLOR, 12'hFFF, 11'd1, 0, 0, 0);
        send_item(MODE_COLOR, 12'd2, 11'h7FF, 0, 0, 0);
        send_item(2'd3, 12'hFFF, 11'h7FF, 12'hFFF, 12'hFFF, 11'h7FF);
        send_item(MODE_QUERY, 0, 0, 12'd1, 12'd16, 11'd1);
        send_item(MODE_QUERY, 0, 0, 12'd1, 12'd16, 11'd0);
        send_item(MODE_QUERY, 0, 0, 12'd2, 12'd9, 11'd2);
        send_item(MODE_QUERY, 0, 0, 12'd9, 12'd2, 11'd1);
        send_item(MODE_QUERY, 0, 0, 12'd16, 12'd16, 11'd1);
        send_item(MODE_QUERY, 0, 0, 12'd1, 12'd16, 11'h7FF);
        send_item(MODE_QUERY, 0, 0, 12'd0, 12'd5, 11'd1025);
        send_item(MODE_QUERY, 0, 0, 12'd3, 12'd8, 11'd1);
    endtask

    task automatic test_random();
        int base;
        int s;
        int e;
        int r;
        base = n_sent;
        while (n_sent - base < 620)
        begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, 16);
            e = (r < 85) ? $urandom_range(s, 16) : $urandom_range(0, 16);
            if (r < 3)
                send_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                send_item(MODE_QUERY, $urandom, $urandom, s, e,
                          (r < 90) ? $urandom_range(0, 5) : $urandom_range(0, 2047));
        end
        send_item(MODE_QUERY, 0, 0, 12'd1, 12'd2, 11'd1);
    endtask

    // watchdog
    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        errors = 0; n_queries = 0; n_loads = 0; n_sent = 0;
        win_lo = 0; win_hi = 0;
        foreach (tour_mem[i]) tour_mem[i] = 0;
        foreach (vcol_mem[i]) vcol_mem[i] = 0;
        foreach (occ_tbl[i]) occ_tbl[i] = 0;
        foreach (atl_tbl[i]) atl_tbl[i] = 0;
        rst_n = 1'b0; in_valid = 1'b0; mode = '0; address = '0; load_value = '0;
        range_start = '0; range_end = '0; min_count = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random();
        in_valid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d loads and %0d window queries with random stalls",
                 n_loads, n_queries);
        if (errors == 0 && expected_counts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
